FILE: hdl/edge_incidence_table_bisection_macros.svh
// ----------------------------------------------------------------------------
// Edge incidence table assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EDGE_INCIDENCE_TABLE_BISECTION_MACROS_SVH
`define EDGE_INCIDENCE_TABLE_BISECTION_MACROS_SVH
`ifndef SYNTH
`define EITB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define EITB_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define EITB_ASSERT_IMP(label, clk, rst_n, a, c)
`define EITB_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hdl/eitb_pkg.sv
// ----------------------------------------------------------------------------
// Edge incidence table package
// Request and result types, codes and sizes.
// ----------------------------------------------------------------------------
package eitb_pkg;
    localparam int MaxEdges    = 1024;
    localparam int MaxVertices = 1024;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_BISECT = 2'd1;
    localparam logic [1:0] FUNC_RDEDGE = 2'd2;
    localparam logic [1:0] FUNC_RDVERT = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EDGE_FULL = 3'd1;
    localparam logic [2:0] ST_VERT_FULL = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_SAME_VERT = 3'd4;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] edge_index;
        logic [9:0] vertex_a;
        logic [9:0] vertex_b;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] edges_used;
        logic [10:0] vertices_used;
        logic [10:0] created_edge;
        logic [10:0] created_vertex;
        logic [9:0]  end_zero;
        logic [9:0]  end_one;
        logic [10:0] link_zero;
        logic [10:0] link_one;
        logic [10:0] head_edge;
    } result_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_RD0, S_RD1, S_HEAD, S_WALK, S_WALKCHK,
        S_FIX, S_FINISH, S_RESULT
    } state_t;
endpackage

FILE: hdl/edge_incidence_table_bisection.sv
// ----------------------------------------------------------------------------
// Edge incidence table with bisection
// Edge table with per-vertex incident-edge lists, add, bisect and reads.
// ----------------------------------------------------------------------------
// Use: drive request and raise start while busy is low; the request is taken
// on that edge and busy rises on the next cycle. One result per request
// appears on result for one cycle with done high; the receiver cannot stall,
// it must take the result in that cycle.
// Bisect first checks whether the edge heads its far vertex's list; if it
// does not, it walks that list to the entry ahead of the edge: each walk
// step reads the link and ends memories (synchronous read) and then checks
// the data, so the walk sets the time.
// Throughput: one request in flight; busy drops in the cycle done is high,
// so the next request can be taken at the edge that takes the result.
// Memories: ends (2 x vertex), links (2 x edge), heads (edge per vertex).
// Ends and links are undefined until written; only entries below the edge
// count are ever used. The head memory is cleared after reset by a pass over
// all MAX_VERTICES entries, one entry a cycle, during which busy stays high.
// ----------------------------------------------------------------------------
module edge_incidence_table_bisection
#(
    parameter int MAX_EDGES    = eitb_pkg::MaxEdges,
    parameter int MAX_VERTICES = eitb_pkg::MaxVertices
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  eitb_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output eitb_pkg::result_t  result
);
    import eitb_pkg::*;

    localparam int EW = $clog2(MAX_EDGES);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = EW + 1;
    localparam int DW = VW + 1;
    localparam logic [CW-1:0] ENONE = CW'(MAX_EDGES);
    localparam logic [DW-1:0] VNONE = DW'(MAX_VERTICES);

    // memories
    logic [2*VW-1:0] ends_mem  [MAX_EDGES];
    logic [2*CW-1:0] links_mem [MAX_EDGES];
    logic [CW-1:0]   heads_mem [MAX_VERTICES];

    logic          ends_we, links_we, heads_we;
    logic [EW-1:0] ends_wa, links_wa, ends_ra, links_ra;
    logic [VW-1:0] heads_wa, heads_ra;
    logic [2*VW-1:0] ends_wd, ends_rd;
    logic [2*CW-1:0] links_wd, links_rd;
    logic [CW-1:0]   heads_wd, heads_rd;

    always_ff @(posedge clk)
    begin
        if (ends_we)
        begin
            ends_mem[ends_wa] <= ends_wd;
        end
        ends_rd <= ends_mem[ends_ra];
    end

    always_ff @(posedge clk)
    begin
        if (links_we)
        begin
            links_mem[links_wa] <= links_wd;
        end
        links_rd <= links_mem[links_ra];
    end

    always_ff @(posedge clk)
    begin
        if (heads_we)
        begin
            heads_mem[heads_wa] <= heads_wd;
        end
        heads_rd <= heads_mem[heads_ra];
    end

    // control and working registers
    state_t state_reg, state_next;
    logic [VW-1:0] clr_reg, clr_next;
    logic [CW-1:0] etot_reg, etot_next;
    logic [DW-1:0] vtot_reg, vtot_next;
    request_t      req_reg, req_next;
    logic [2:0]    st_reg, st_next;
    logic [2*VW-1:0] e_ends_reg, e_ends_next;    // ends of bisected or read edge
    logic [2*CW-1:0] e_links_reg, e_links_next;
    logic [CW-1:0]   hd_reg, hd_next;
    logic [CW-1:0]   p_reg, p_next;              // walk pointer
    logic [CW-1:0]   steps_reg, steps_next;
    logic            slot_reg, slot_next;
    logic [2*CW-1:0] p_links_reg, p_links_next;
    logic            found_reg, found_next;
    result_t         res_reg, res_next;
    logic            done_reg, done_next;

    logic [VW-1:0] va, vb, front, back;
    logic [EW-1:0] ei;
    logic          ei_bad, add_bad_idx;
    logic [VW-1:0] vmax;
    logic [DW-1:0] top;

    always_comb
    begin
        va    = req_reg.vertex_a[VW-1:0];
        vb    = req_reg.vertex_b[VW-1:0];
        ei    = req_reg.edge_index[EW-1:0];
        ei_bad = (32'(req_reg.edge_index) >= 32'(etot_reg)) ||
                 (32'(req_reg.edge_index) >= 32'(MAX_EDGES));
        add_bad_idx = (32'(req_reg.vertex_a) >= 32'(MAX_VERTICES)) ||
                      (32'(req_reg.vertex_b) >= 32'(MAX_VERTICES));
        vmax  = (va > vb) ? va : vb;
        top   = DW'(vmax) + DW'(1);
        back  = e_ends_reg[2*VW-1:VW];
        front = e_ends_reg[VW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_reg) == MAX_VERTICES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_RESULT;
                case (req_reg.func)
                    FUNC_ADD:
                    begin
                        if (!add_bad_idx && va != vb && etot_reg < ENONE)
                        begin
                            state_next = S_RD0;
                        end
                    end
                    FUNC_BISECT:
                    begin
                        if (!ei_bad && etot_reg < ENONE && vtot_reg < VNONE)
                        begin
                            state_next = S_RD0;
                        end
                    end
                    FUNC_RDEDGE:
                    begin
                        if (!ei_bad)
                        begin
                            state_next = S_RD0;
                        end
                    end
                    default:
                    begin
                        if (vtot_reg > DW'(req_reg.vertex_a))
                        begin
                            state_next = S_RD0;
                        end
                    end
                endcase
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                if (req_reg.func == FUNC_BISECT)
                begin
                    state_next = S_HEAD;
                end
                else if (req_reg.func == FUNC_ADD)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_HEAD:
            begin
                // head of the far vertex is in heads_rd
                if (heads_rd == CW'(ei) || heads_rd >= etot_reg)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (found_reg || p_reg >= etot_reg || 32'(steps_reg) >= MAX_EDGES)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    state_next = S_WALKCHK;
                end
            end
            S_WALKCHK:
            begin
                state_next = S_WALK;
            end
            S_FIX:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    logic cur_slot;
    always_comb
    begin
        cur_slot = (ends_rd[2*VW-1:VW] == front) ? 1'b0 : 1'b1;
    end

    always_comb
    begin
        clr_next     = clr_reg;
        etot_next    = etot_reg;
        vtot_next    = vtot_reg;
        req_next     = req_reg;
        st_next      = st_reg;
        e_ends_next  = e_ends_reg;
        e_links_next = e_links_reg;
        hd_next      = hd_reg;
        p_next       = p_reg;
        steps_next   = steps_reg;
        slot_next    = slot_reg;
        p_links_next = p_links_reg;
        found_next   = found_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        ends_we  = 1'b0;
        links_we = 1'b0;
        heads_we = 1'b0;
        ends_wa  = ei;
        links_wa = ei;
        heads_wa = va;
        ends_wd  = '0;
        links_wd = '0;
        heads_wd = ENONE;
        ends_ra  = ei;
        links_ra = ei;
        heads_ra = va;

        case (state_reg)
            S_CLEAR:
            begin
                heads_we = 1'b1;
                heads_wa = clr_reg;
                heads_wd = ENONE;
                clr_next = clr_reg + VW'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                end
            end
            S_DECIDE:
            begin
                st_next = ST_OK;
                found_next = 1'b0;
                steps_next = '0;
                case (req_reg.func)
                    FUNC_ADD:
                    begin
                        if (add_bad_idx)
                            st_next = ST_BAD_INDEX;
                        else if (va == vb)
                            st_next = ST_SAME_VERT;
                        else if (etot_reg >= ENONE)
                            st_next = ST_EDGE_FULL;
                    end
                    FUNC_BISECT:
                    begin
                        if (ei_bad)
                            st_next = ST_BAD_INDEX;
                        else if (etot_reg >= ENONE)
                            st_next = ST_EDGE_FULL;
                        else if (vtot_reg >= VNONE)
                            st_next = ST_VERT_FULL;
                    end
                    FUNC_RDEDGE:
                    begin
                        if (ei_bad)
                            st_next = ST_BAD_INDEX;
                    end
                    default:
                    begin
                        if (!(vtot_reg > DW'(req_reg.vertex_a)))
                            st_next = ST_BAD_INDEX;
                    end
                endcase
                // ends/links/heads reads issued at ei and va
            end
            S_RD0:
            begin
                heads_ra = vb;
                e_ends_next  = ends_rd;
                e_links_next = links_rd;
                hd_next      = heads_rd;
            end
            S_RD1:
            begin
                if (req_reg.func == FUNC_ADD)
                begin
                    // hd_reg = head[va], heads_rd = head[vb]
                    e_links_next = {hd_reg, heads_rd};
                end
                else if (req_reg.func == FUNC_BISECT)
                begin
                    heads_ra = front;
                end
            end
            default:
            begin
            end
        endcase

        // walk over the far vertex's list
        case (state_reg)
            S_RD1:
            begin
                steps_next = '0;
                slot_next  = 1'b1;
            end
            S_HEAD:
            begin
                // head hit leaves p at ei with slot set and no steps
                p_next     = heads_rd;
                found_next = (heads_rd == CW'(ei));
                slot_next  = 1'b1;
            end
            S_WALK:
            begin
                links_ra = p_reg[EW-1:0];
                ends_ra  = p_reg[EW-1:0];
            end
            S_WALKCHK:
            begin
                links_ra = p_reg[EW-1:0];
                ends_ra  = p_reg[EW-1:0];
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_WALKCHK)
        begin
            p_links_next = links_rd;
            slot_next    = cur_slot;
            if ((cur_slot ? links_rd[CW-1:0] : links_rd[2*CW-1:CW]) == CW'(ei))
            begin
                found_next = 1'b1;
            end
            else
            begin
                p_next     = cur_slot ? links_rd[CW-1:0] : links_rd[2*CW-1:CW];
                steps_next = steps_reg + CW'(1);
            end
        end

        case (state_reg)
            S_FIX:
            begin
                if (found_reg)
                begin
                    if (p_reg == CW'(ei) && steps_reg == '0 && slot_reg)
                    begin
                        heads_we = 1'b1;
                        heads_wa = front;
                        heads_wd = etot_reg;
                    end
                    else
                    begin
                        links_we = 1'b1;
                        links_wa = p_reg[EW-1:0];
                        links_wd = slot_reg ? {p_links_reg[2*CW-1:CW], etot_reg}
                                            : {etot_reg, p_links_reg[CW-1:0]};
                    end
                end
                // old edge: ends (back, nv)
                ends_we = 1'b1;
                ends_wa = ei;
                ends_wd = {back, vtot_reg[VW-1:0]};
            end
            S_FINISH:
            begin
                if (req_reg.func == FUNC_ADD)
                begin
                    ends_we  = 1'b1;
                    ends_wa  = etot_reg[EW-1:0];
                    ends_wd  = {va, vb};
                    links_we = 1'b1;
                    links_wa = etot_reg[EW-1:0];
                    links_wd = e_links_reg;
                    heads_we = 1'b1;
                    heads_wa = va;
                    heads_wd = etot_reg;
                    etot_next = etot_reg + CW'(1);
                    if (top > vtot_reg)
                        vtot_next = top;
                end
                else
                begin
                    ends_we  = 1'b1;
                    ends_wa  = etot_reg[EW-1:0];
                    ends_wd  = {vtot_reg[VW-1:0], front};
                    links_we = 1'b1;
                    links_wa = etot_reg[EW-1:0];
                    links_wd = {ENONE, e_links_reg[CW-1:0]};
                    heads_we = 1'b1;
                    heads_wa = vtot_reg[VW-1:0];
                    heads_wd = CW'(ei);
                    etot_next = etot_reg + CW'(1);
                    vtot_next = vtot_reg + DW'(1);
                end
            end
            S_RESULT:
            begin
                if (req_reg.func == FUNC_ADD && st_reg == ST_OK)
                begin
                    heads_we = 1'b1;
                    heads_wa = vb;
                    heads_wd = etot_reg - CW'(1);
                end
                else if (req_reg.func == FUNC_BISECT && st_reg == ST_OK)
                begin
                    links_we = 1'b1;
                    links_wa = ei;
                    links_wd = {e_links_reg[2*CW-1:CW], etot_reg - CW'(1)};
                end
                done_next = 1'b1;
                res_next.status         = st_reg;
                res_next.edges_used     = 11'(etot_reg);
                res_next.vertices_used  = 11'(vtot_reg);
                res_next.created_edge   = 11'(ENONE);
                res_next.created_vertex = 11'(VNONE);
                res_next.end_zero       = '0;
                res_next.end_one        = '0;
                res_next.link_zero      = 11'(ENONE);
                res_next.link_one       = 11'(ENONE);
                res_next.head_edge      = 11'(ENONE);
                if (st_reg == ST_OK)
                begin
                    case (req_reg.func)
                        FUNC_ADD:
                            res_next.created_edge = 11'(etot_reg - CW'(1));
                        FUNC_BISECT:
                        begin
                            res_next.created_edge   = 11'(etot_reg - CW'(1));
                            res_next.created_vertex = 11'(vtot_reg - DW'(1));
                        end
                        FUNC_RDEDGE:
                        begin
                            res_next.end_zero  = 10'(e_ends_reg[2*VW-1:VW]);
                            res_next.end_one   = 10'(e_ends_reg[VW-1:0]);
                            res_next.link_zero = 11'(e_links_reg[2*CW-1:CW]);
                            res_next.link_one  = 11'(e_links_reg[CW-1:0]);
                        end
                        default:
                            res_next.head_edge = 11'(hd_reg);
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            etot_reg  <= '0;
            vtot_reg  <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            steps_reg <= '0;
            slot_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            etot_reg  <= etot_next;
            vtot_reg  <= vtot_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            steps_reg <= steps_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        st_reg      <= st_next;
        e_ends_reg  <= e_ends_next;
        e_links_reg <= e_links_next;
        hd_reg      <= hd_next;
        p_reg       <= p_next;
        p_links_reg <= p_links_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        busy   = (state_reg != S_IDLE);
        done   = done_reg;
        result = res_reg;
    end

    `include "edge_incidence_table_bisection_macros.svh"

    `EITB_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy)
    `EITB_ASSERT_NXT(a_done_idle, clk, rst_n, done, !done)
    `EITB_ASSERT_IMP(a_counts, clk, rst_n, 1'b1, etot_reg <= ENONE && vtot_reg <= VNONE)
endmodule

FILE: tb/sv/edge_incidence_table_bisection_checker.sv
// ----------------------------------------------------------------------------
// Edge incidence table result checker
// Watches accepted requests, keeps a shadow of the edge and vertex tables,
// and compares every strobed result field by field against the prediction.
// ----------------------------------------------------------------------------
module edge_incidence_table_bisection_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  eitb_pkg::request_t request,
    input  logic               done,
    input  eitb_pkg::result_t  result,
    output int                 fail_count,
    output int                 pending
);
    import eitb_pkg::*;

    localparam logic [10:0] EdgeNone = 11'(MaxEdges);
    localparam logic [10:0] VertNone = 11'(MaxVertices);

    logic [9:0]  end_tab  [MaxEdges][2];
    logic [10:0] link_tab [MaxEdges][2];
    logic [10:0] head_tab [MaxVertices];
    int          n_edges;
    int          n_verts;
    result_t     due_q [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    // Apply one request to the shadow tables and return the result it gives.
    function automatic result_t table_apply(input request_t rq);
        result_t r;
        int ne, nv, fr, bk, p, steps, s;
        logic [10:0] nb, nf;
        r = '0;
        r.created_edge   = EdgeNone;
        r.created_vertex = VertNone;
        r.link_zero      = EdgeNone;
        r.link_one       = EdgeNone;
        r.head_edge      = EdgeNone;
        r.status         = ST_OK;
        case (rq.func)
            FUNC_ADD:
            begin
                if (rq.vertex_a == rq.vertex_b)
                    r.status = ST_SAME_VERT;
                else if (n_edges >= MaxEdges)
                    r.status = ST_EDGE_FULL;
                else
                begin
                    ne = n_edges;
                    end_tab[ne][0]  = rq.vertex_a;
                    end_tab[ne][1]  = rq.vertex_b;
                    link_tab[ne][0] = head_tab[rq.vertex_a];
                    link_tab[ne][1] = head_tab[rq.vertex_b];
                    head_tab[rq.vertex_a] = 11'(ne);
                    head_tab[rq.vertex_b] = 11'(ne);
                    n_edges = ne + 1;
                    nv = ((rq.vertex_a > rq.vertex_b) ? rq.vertex_a : rq.vertex_b) + 1;
                    if (nv > n_verts)
                        n_verts = nv;
                    r.created_edge = 11'(ne);
                end
            end
            FUNC_BISECT:
            begin
                if (rq.edge_index >= n_edges)
                    r.status = ST_BAD_INDEX;
                else if (n_edges >= MaxEdges)
                    r.status = ST_EDGE_FULL;
                else if (n_verts >= MaxVertices)
                    r.status = ST_VERT_FULL;
                else
                begin
                    ne = n_edges;
                    nv = n_verts;
                    bk = end_tab[rq.edge_index][0];
                    fr = end_tab[rq.edge_index][1];
                    nb = link_tab[rq.edge_index][0];
                    nf = link_tab[rq.edge_index][1];
                    p  = head_tab[fr];
                    steps = 0;
                    // relink the far vertex's predecessor of the split edge
                    if (p == rq.edge_index)
                        head_tab[fr] = 11'(ne);
                    else
                    begin
                        while (p < n_edges && steps < MaxEdges)
                        begin
                            s = (end_tab[p][0] == fr) ? 0 : 1;
                            if (link_tab[p][s] == rq.edge_index)
                            begin
                                link_tab[p][s] = 11'(ne);
                                break;
                            end
                            p = link_tab[p][s];
                            steps++;
                        end
                    end
                    end_tab[rq.edge_index][0]  = 10'(bk);
                    end_tab[rq.edge_index][1]  = 10'(nv);
                    link_tab[rq.edge_index][0] = nb;
                    link_tab[rq.edge_index][1] = 11'(ne);
                    end_tab[ne][0]  = 10'(nv);
                    end_tab[ne][1]  = 10'(fr);
                    link_tab[ne][0] = EdgeNone;
                    link_tab[ne][1] = nf;
                    head_tab[nv] = 11'(rq.edge_index);
                    n_edges = ne + 1;
                    n_verts = nv + 1;
                    r.created_edge   = 11'(ne);
                    r.created_vertex = 11'(nv);
                end
            end
            FUNC_RDEDGE:
            begin
                if (rq.edge_index >= n_edges)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    r.end_zero  = end_tab[rq.edge_index][0];
                    r.end_one   = end_tab[rq.edge_index][1];
                    r.link_zero = link_tab[rq.edge_index][0];
                    r.link_one  = link_tab[rq.edge_index][1];
                end
            end
            default:
            begin
                if (rq.vertex_a >= n_verts)
                    r.status = ST_BAD_INDEX;
                else
                    r.head_edge = head_tab[rq.vertex_a];
            end
        endcase
        r.edges_used    = 11'(n_edges);
        r.vertices_used = 11'(n_verts);
        return r;
    endfunction

    assign pending = due_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t w;
        if (!rst_n)
        begin
            n_edges = 0;
            n_verts = 0;
            for (int i = 0; i < MaxVertices; i++)
                head_tab[i] = EdgeNone;
            due_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (due_q.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    w = due_q.pop_front();
                    if (result.status != w.status)
                        report_mismatch("status", result.status, w.status);
                    if (result.edges_used != w.edges_used)
                        report_mismatch("edges_used", result.edges_used, w.edges_used);
                    if (result.vertices_used != w.vertices_used)
                        report_mismatch("vertices_used", result.vertices_used,
                                        w.vertices_used);
                    if (result.created_edge != w.created_edge)
                        report_mismatch("created_edge", result.created_edge,
                                        w.created_edge);
                    if (result.created_vertex != w.created_vertex)
                        report_mismatch("created_vertex", result.created_vertex,
                                        w.created_vertex);
                    if (result.end_zero != w.end_zero)
                        report_mismatch("end_zero", result.end_zero, w.end_zero);
                    if (result.end_one != w.end_one)
                        report_mismatch("end_one", result.end_one, w.end_one);
                    if (result.link_zero != w.link_zero)
                        report_mismatch("link_zero", result.link_zero, w.link_zero);
                    if (result.link_one != w.link_one)
                        report_mismatch("link_one", result.link_one, w.link_one);
                    if (result.head_edge != w.head_edge)
                        report_mismatch("head_edge", result.head_edge, w.head_edge);
                end
            end
            if (start && !busy)
                due_q.insert(due_q.size(), table_apply(request));
        end
    end
endmodule

FILE: tb/sv/edge_incidence_table_bisection_tb.sv
// ----------------------------------------------------------------------------
// Edge incidence table testbench
// Directed requests for every function and error case, then random mesh
// building and bisection in several idling phases; a checker module
// predicts and compares each result.
// ----------------------------------------------------------------------------
module edge_incidence_table_bisection_tb;
    import eitb_pkg::*;

    // quiet-cycle limit: head clear pass plus a worst-case bisect walk
    localparam int WatchLimit = 20000;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;
    int       fail_count;
    int       pending;
    int       quiet;
    int       idle_pct;
    int       mesh_edges;   // edges the stimulus believes exist
    int       mesh_verts;

    edge_incidence_table_bisection dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    edge_incidence_table_bisection_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: ends the run if nothing is taken or returned for too long.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WatchLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Issue one request: random gap first, then hold start until busy is low.
    // start stays high after the take; busy masks it until the next call.
    task automatic send_request(input logic [1:0] f, input logic [9:0] ei,
                                input logic [9:0] va, input logic [9:0] vb);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= '{func: f, edge_index: ei, vertex_a: va, vertex_b: vb};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // shadow counts for legal stimulus indices and the edge-table fill
        if (f == FUNC_ADD && va != vb && mesh_edges < MaxEdges)
        begin
            mesh_edges++;
            if (((va > vb) ? va : vb) + 1 > mesh_verts)
                mesh_verts = ((va > vb) ? va : vb) + 1;
        end
        else if (f == FUNC_BISECT && ei < mesh_edges && mesh_edges < MaxEdges
                 && mesh_verts < MaxVertices)
        begin
            mesh_edges++;
            mesh_verts++;
        end
    endtask

    // Random request, mostly aimed at existing edges and vertices.
    task automatic random_request();
        int r;
        logic [9:0] a, b, e;
        r = $urandom_range(99);
        e = (mesh_edges > 0 && $urandom_range(9) > 0)
            ? 10'($urandom_range(mesh_edges - 1)) : 10'($urandom);
        a = (mesh_verts > 1 && $urandom_range(3) > 0)
            ? 10'($urandom_range(mesh_verts - 1)) : 10'($urandom_range(63));
        b = (mesh_verts > 1 && $urandom_range(3) > 0)
            ? 10'($urandom_range(mesh_verts - 1)) : 10'($urandom_range(63));
        if ($urandom_range(49) == 0)
            b = a;
        if ($urandom_range(99) == 0)
            a = 10'($urandom);
        if (r < 30)
            send_request(FUNC_ADD, 10'($urandom), a, b);
        else if (r < 60)
            send_request(FUNC_BISECT, e, 10'($urandom), 10'($urandom));
        else if (r < 80)
            send_request(FUNC_RDEDGE, e, 10'($urandom), 10'($urandom));
        else
            send_request(FUNC_RDVERT, 10'($urandom), a, 10'($urandom));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        idle_pct   = 0;
        mesh_edges = 0;
        mesh_verts = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-table errors, self-loop, extremes, list relinking.
        send_request(FUNC_RDEDGE, 10'd0, 10'd0, 10'd0);
        send_request(FUNC_RDVERT, 10'd0, 10'd0, 10'd0);
        send_request(FUNC_BISECT, 10'd0, 10'd0, 10'd0);
        send_request(FUNC_ADD, 10'd0, 10'd5, 10'd5);
        send_request(FUNC_ADD, 10'd1023, 10'd0, 10'd1);
        send_request(FUNC_ADD, 10'd0, 10'd2, 10'd1);
        send_request(FUNC_ADD, 10'd0, 10'd3, 10'd1);
        send_request(FUNC_ADD, 10'd0, 10'd1, 10'd0);   // duplicate
        send_request(FUNC_BISECT, 10'd0, 10'd0, 10'd0);   // far end deep in list
        send_request(FUNC_BISECT, 10'd2, 10'd0, 10'd0);
        send_request(FUNC_BISECT, 10'd3, 10'd0, 10'd0);   // far end at list head
        send_request(FUNC_RDEDGE, 10'd0, 10'd0, 10'd0);
        send_request(FUNC_RDEDGE, 10'd4, 10'd0, 10'd0);
        send_request(FUNC_RDEDGE, 10'd1023, 10'd0, 10'd0);
        send_request(FUNC_RDVERT, 10'd0, 10'd1, 10'd0);
        send_request(FUNC_RDVERT, 10'd0, 10'd4, 10'd0);
        send_request(FUNC_ADD, 10'd0, 10'd20, 10'd30);    // isolated vertices below
        send_request(FUNC_RDVERT, 10'd0, 10'd25, 10'd0);
        send_request(FUNC_RDVERT, 10'd0, 10'd1023, 10'd0);
        send_request(FUNC_ADD, 10'd0, 10'd1023, 10'd1022); // vertex table full
        send_request(FUNC_BISECT, 10'd1, 10'd0, 10'd0);
        send_request(FUNC_RDVERT, 10'd0, 10'd1023, 10'd1023);
        send_request(FUNC_RDEDGE, 10'd8, 10'd1023, 10'd1023);

        // Random phases; the vertex table is full, so fill the edge table too.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 52;
                2: idle_pct = 0;
                default: idle_pct = 30;
            endcase
            for (int i = 0; i < 110; i++)
                random_request();
        end
        // edge table full now reachable: probe both full paths
        while (mesh_edges < MaxEdges)
            send_request(FUNC_ADD, 10'd0, 10'($urandom_range(1023)),
                         10'($urandom_range(1023)) ^ 10'd1 ^ 10'd0);
        send_request(FUNC_ADD, 10'd0, 10'd0, 10'd1);
        send_request(FUNC_BISECT, 10'd0, 10'd0, 10'd0);
        send_request(FUNC_RDEDGE, 10'd1023, 10'd0, 10'd0);
        start <= 1'b0;

        while (pending > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
